@@ src/signed_radix_digit_emitter_defines.svh @@
// Assertion macros for the signed radix digit emitter.
// Included by the top level; expects clk and rst_n in scope.
`ifndef SIGNED_RADIX_DIGIT_EMITTER_DEFINES_SVH
`define SIGNED_RADIX_DIGIT_EMITTER_DEFINES_SVH

// Same-cycle implication, checked only out of reset.
`define SDRE_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked only out of reset.
`define SDRE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/sdre_pkg.sv @@
// Shared constants, types and helper functions of the signed radix digit emitter.
// No dependencies; imported by every module of the block.
package sdre_pkg;

  localparam int NUM_W       = 32;
  localparam int CFG_W       = 64;
  localparam int CFG_IDX_W   = 1;
  localparam int CHAR_W      = 8;
  localparam int MAX_RADIX   = 16;
  localparam int ALPHA_SLOTS = 16;
  localparam int ALPHA_CAP   = (MAX_RADIX < ALPHA_SLOTS) ? MAX_RADIX : ALPHA_SLOTS;
  localparam int IDX_W       = $clog2(ALPHA_SLOTS);
  localparam int LEN_W       = $clog2(ALPHA_SLOTS + 1);
  localparam int DIGIT_SLOTS = 32;
  localparam int POS_W       = $clog2(DIGIT_SLOTS);
  localparam int CNT_W       = $clog2(DIGIT_SLOTS + 1);
  localparam int Q_DEPTH     = 2;
  localparam int QPTR_W      = $clog2(Q_DEPTH);
  localparam int QCNT_W      = $clog2(Q_DEPTH + 1);
  localparam int REM_W       = LEN_W + 1;

  localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_LOW  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_HIGH = 1'b1;

  // One finished number waiting in the queue.
  typedef struct packed {
    logic             neg;
    logic [CNT_W-1:0] cnt;
  } desc_t;

  // Digit write from the front into its bank.
  typedef struct packed {
    logic             en;
    logic [POS_W-1:0] pos;
    logic [IDX_W-1:0] digit;
  } dig_wr_t;

  // Front to queue.
  typedef struct packed {
    dig_wr_t wr;
    logic    push;
    desc_t   desc;
  } front_q_t;

  // Back to queue.
  typedef struct packed {
    logic             rd_en;
    logic [POS_W-1:0] rd_pos;
    logic             pop;
  } back_q_t;

  // Queue to back.
  typedef struct packed {
    logic             head_valid;
    desc_t            head;
    logic [IDX_W-1:0] rd_digit;
  } q_back_t;

  // Byte k of the alphabet, entry 0 in the lowest byte of the low word.
  function automatic logic [CHAR_W-1:0] alpha_entry(input logic [CFG_W-1:0] lo,
                                                    input logic [CFG_W-1:0] hi,
                                                    input logic [IDX_W-1:0] k);
    logic [2*CFG_W-1:0] w;
    w = {hi, lo};
    return w[{k, 3'b000} +: CHAR_W];
  endfunction

  // floor(2^32 / d); the quotient estimate from it is at most one short.
  function automatic logic [NUM_W-1:0] recip(input logic [LEN_W-1:0] d);
    logic [NUM_W-1:0] r;
    unique case (d)
      5'd2:    r = 32'h8000_0000;
      5'd3:    r = 32'h5555_5555;
      5'd4:    r = 32'h4000_0000;
      5'd5:    r = 32'h3333_3333;
      5'd6:    r = 32'h2AAA_AAAA;
      5'd7:    r = 32'h2492_4924;
      5'd8:    r = 32'h2000_0000;
      5'd9:    r = 32'h1C71_C71C;
      5'd10:   r = 32'h1999_9999;
      5'd11:   r = 32'h1745_D174;
      5'd12:   r = 32'h1555_5555;
      5'd13:   r = 32'h13B1_3B13;
      5'd14:   r = 32'h1249_2492;
      5'd15:   r = 32'h1111_1111;
      5'd16:   r = 32'h1000_0000;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

@@ src/sdre_front.sv @@
// Front end: accepts a number, checks the alphabet and peels off digits,
// least significant first, by reciprocal multiplication. Uses sdre_pkg.
module sdre_front (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  logic signed [sdre_pkg::NUM_W-1:0]   in_number,
  input  logic        [sdre_pkg::CFG_W-1:0]   alpha_lo,
  input  logic        [sdre_pkg::CFG_W-1:0]   alpha_hi,
  input  logic                                q_full,
  output logic                                busy,
  output sdre_pkg::front_q_t                  fq
);
  import sdre_pkg::*;

  typedef enum logic [2:0] {
    F_IDLE = 3'b001,
    F_MUL  = 3'b010,
    F_FIX  = 3'b100
  } front_state_t;

  front_state_t       state_r, state_nxt;
  logic [NUM_W-1:0]   mag_r, mag_nxt;
  logic               neg_r, neg_nxt;
  logic [POS_W-1:0]   pos_r, pos_nxt;
  logic [NUM_W-1:0]   qest_r, qest_nxt;

  logic [CHAR_W-1:0]  ent [ALPHA_SLOTS];
  logic [LEN_W-1:0]   alen;
  logic               aok;
  logic [2*NUM_W-1:0] prod;
  logic [REM_W-1:0]   d6;
  logic [REM_W-1:0]   low_prod;
  logic [REM_W-1:0]   rem6;
  logic               fix;
  logic [NUM_W-1:0]   quot;
  logic [IDX_W-1:0]   digit;
  logic               done;
  logic [NUM_W-1:0]   in_u;

  // Alphabet length: bytes before the first zero, capped.
  always_comb begin
    for (int k = 0; k < ALPHA_SLOTS; k++) begin
      ent[k] = alpha_entry(alpha_lo, alpha_hi, IDX_W'(k));
    end
    alen = LEN_W'(ALPHA_CAP);
    for (int k = ALPHA_CAP - 1; k >= 0; k--) begin
      if (ent[k] == '0) begin
        alen = LEN_W'(k);
      end
    end
  end

  // Alphabet is usable when long enough, sign-free and without repeats.
  always_comb begin
    aok = (alen >= LEN_W'(2));
    for (int a = 0; a < ALPHA_CAP; a++) begin
      if (LEN_W'(a) < alen) begin
        if (ent[a] == CH_PLUS || ent[a] == CH_MINUS) begin
          aok = 1'b0;
        end
        for (int b = a + 1; b < ALPHA_CAP; b++) begin
          if (LEN_W'(b) < alen && ent[a] == ent[b]) begin
            aok = 1'b0;
          end
        end
      end
    end
  end

  // Quotient estimate and its one-step correction on the low bits.
  always_comb begin
    prod     = {{NUM_W{1'b0}}, mag_r} * {{NUM_W{1'b0}}, recip(alen)};
    d6       = {1'b0, alen};
    low_prod = qest_r[REM_W-1:0] * d6;
    rem6     = mag_r[REM_W-1:0] - low_prod;
    fix      = (rem6 >= d6);
    quot     = fix ? (qest_r + NUM_W'(1)) : qest_r;
    digit    = fix ? IDX_W'(rem6 - d6) : rem6[IDX_W-1:0];
    done     = (quot == '0) || (pos_r == POS_W'(DIGIT_SLOTS - 1));
    in_u     = unsigned'(in_number);
  end

  // Sequencer: a multiply state (F_MUL), then a correction state (F_FIX), for each digit.
  always_comb begin
    state_nxt = state_r;
    mag_nxt   = mag_r;
    neg_nxt   = neg_r;
    pos_nxt   = pos_r;
    qest_nxt  = qest_r;
    unique case (state_r)
      F_IDLE: begin
        if (start && !q_full) begin
          neg_nxt   = in_u[NUM_W-1];
          mag_nxt   = in_u[NUM_W-1] ? (~in_u + NUM_W'(1)) : in_u;
          pos_nxt   = '0;
          state_nxt = F_MUL;
        end
      end
      F_MUL: begin
        qest_nxt  = prod[2*NUM_W-1:NUM_W];
        state_nxt = aok ? F_FIX : F_IDLE;
      end
      F_FIX: begin
        mag_nxt = quot;
        if (done) begin
          state_nxt = F_IDLE;
        end else begin
          pos_nxt   = pos_r + POS_W'(1);
          state_nxt = F_MUL;
        end
      end
      default: state_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mag_r  <= mag_nxt;
    neg_r  <= neg_nxt;
    pos_r  <= pos_nxt;
    qest_r <= qest_nxt;
  end

  // Digit writes and the hand-off of a finished number.
  always_comb begin
    fq.wr.en     = (state_r == F_FIX);
    fq.wr.pos    = pos_r;
    fq.wr.digit  = digit;
    fq.push      = (state_r == F_FIX) && done;
    fq.desc.neg  = neg_r;
    fq.desc.cnt  = CNT_W'(pos_r) + CNT_W'(1);
  end

  assign busy = (state_r != F_IDLE) || q_full;

endmodule

@@ src/sdre_queue.sv @@
// Two-entry queue of finished numbers, each with its own bank of digit memory.
// Sits between sdre_front and sdre_back. Uses sdre_pkg.
module sdre_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  sdre_pkg::front_q_t fq,
  input  sdre_pkg::back_q_t  bq,
  output logic               q_full,
  output sdre_pkg::q_back_t  qb
);
  import sdre_pkg::*;

  desc_t             desc_r [Q_DEPTH];
  logic [QPTR_W-1:0] wp_r, wp_nxt;
  logic [QPTR_W-1:0] rp_r, rp_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic [IDX_W-1:0]  mem [Q_DEPTH*DIGIT_SLOTS];
  logic [IDX_W-1:0]  rd_r;

  // Pointer and fill-count update.
  always_comb begin
    wp_nxt  = fq.push ? (wp_r + QPTR_W'(1)) : wp_r;
    rp_nxt  = bq.pop ? (rp_r + QPTR_W'(1)) : rp_r;
    cnt_nxt = cnt_r;
    if (fq.push && !bq.pop) begin
      cnt_nxt = cnt_r + QCNT_W'(1);
    end else if (bq.pop && !fq.push) begin
      cnt_nxt = cnt_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // Descriptor storage.
  always_ff @(posedge clk) begin
    if (fq.push) begin
      desc_r[wp_r] <= fq.desc;
    end
  end

  // Digit memory: the front fills bank wp, the back reads bank rp.
  always_ff @(posedge clk) begin
    if (fq.wr.en) begin
      mem[{wp_r, fq.wr.pos}] <= fq.wr.digit;
    end
  end

  always_ff @(posedge clk) begin
    if (bq.rd_en) begin
      rd_r <= mem[{rp_r, bq.rd_pos}];
    end
  end

  always_comb begin
    q_full        = (cnt_r == QCNT_W'(Q_DEPTH));
    qb.head_valid = (cnt_r != '0);
    qb.head       = desc_r[rp_r];
    qb.rd_digit   = rd_r;
  end

endmodule

@@ src/sdre_back.sv @@
// Back end: emits the sign and the stored digits, most significant first,
// mapping each digit through the alphabet. Uses sdre_pkg.
module sdre_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  sdre_pkg::q_back_t             qb,
  input  logic [sdre_pkg::CFG_W-1:0]    alpha_lo,
  input  logic [sdre_pkg::CFG_W-1:0]    alpha_hi,
  output sdre_pkg::back_q_t             bq,
  output logic                          out_strobe,
  output logic [sdre_pkg::CHAR_W-1:0]   out_char,
  output logic                          out_final_char
);
  import sdre_pkg::*;

  typedef enum logic [2:0] {
    B_IDLE = 3'b001,
    B_SIGN = 3'b010,
    B_EMIT = 3'b100
  } back_state_t;

  back_state_t       state_r, state_nxt;
  logic [POS_W-1:0]  k_r, k_nxt;
  logic              strobe_r, strobe_nxt;
  logic [CHAR_W-1:0] char_r, char_nxt;
  logic              final_r, final_nxt;

  // Emission sequencer; each digit read is issued ahead of its use into the queue's read register.
  always_comb begin
    state_nxt  = state_r;
    k_nxt      = k_r;
    strobe_nxt = 1'b0;
    char_nxt   = char_r;
    final_nxt  = final_r;
    bq.rd_en   = 1'b0;
    bq.rd_pos  = k_r;
    bq.pop     = 1'b0;
    unique case (state_r)
      B_IDLE: begin
        if (qb.head_valid) begin
          bq.rd_en  = 1'b1;
          bq.rd_pos = POS_W'(qb.head.cnt - CNT_W'(1));
          k_nxt     = POS_W'(qb.head.cnt - CNT_W'(1));
          state_nxt = qb.head.neg ? B_SIGN : B_EMIT;
        end
      end
      B_SIGN: begin
        strobe_nxt = 1'b1;
        char_nxt   = CH_MINUS;
        final_nxt  = 1'b0;
        state_nxt  = B_EMIT;
      end
      B_EMIT: begin
        strobe_nxt = 1'b1;
        char_nxt   = alpha_entry(alpha_lo, alpha_hi, qb.rd_digit);
        final_nxt  = (k_r == '0);
        if (k_r != '0) begin
          bq.rd_en  = 1'b1;
          bq.rd_pos = k_r - POS_W'(1);
          k_nxt     = k_r - POS_W'(1);
        end else begin
          bq.pop    = 1'b1;
          state_nxt = B_IDLE;
        end
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= B_IDLE;
      strobe_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      strobe_r <= strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    k_r     <= k_nxt;
    char_r  <= char_nxt;
    final_r <= final_nxt;
  end

  assign out_strobe     = strobe_r;
  assign out_char       = char_r;
  assign out_final_char = final_r;

endmodule

@@ src/signed_radix_digit_emitter.sv @@
// Top level of the signed radix digit emitter: configuration registers,
// front end, digit queue and back end. Uses sdre_pkg and the defines header.
//
// Usage. A number is taken on in_number at a clock edge where start is high
// and busy is low. Its text in the configured radix comes out one character
// per beat on out_char, qualified by out_strobe for one cycle each, most
// significant digit first, a '-' first for negatives; out_final_char marks
// the last beat. The receiver cannot stall; every beat must be taken.
// The alphabet is written through cfg_we/cfg_index/cfg_data while idle:
// index 0 holds entries 0..7, index 1 entries 8..15, one byte each.
// A bad or too short alphabet makes a number produce no beats at all.
// Timing: the front works out each digit by a 32x32 reciprocal multiply
// and then the remainder correction. The beats of a number start only
// once all its digits are in the queue, then come one beat per cycle.
// A two-entry queue lets the front work on the next number while the
// back is still emitting.
// Reset (synchronous, rst_n low) clears the alphabet, queue and sequencers.
`include "signed_radix_digit_emitter_defines.svh"

module signed_radix_digit_emitter (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  output logic                                 busy,
  input  logic signed [sdre_pkg::NUM_W-1:0]    in_number,
  output logic                                 out_strobe,
  output logic        [sdre_pkg::CHAR_W-1:0]   out_char,
  output logic                                 out_final_char,
  input  logic                                 cfg_we,
  input  logic        [sdre_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic        [sdre_pkg::CFG_W-1:0]    cfg_data
);
  import sdre_pkg::*;

  logic [CFG_W-1:0] alpha_lo_r, alpha_lo_nxt;
  logic [CFG_W-1:0] alpha_hi_r, alpha_hi_nxt;
  front_q_t         fq;
  back_q_t          bq;
  q_back_t          qb;
  logic             q_full;

  // Alphabet registers.
  always_comb begin
    alpha_lo_nxt = alpha_lo_r;
    alpha_hi_nxt = alpha_hi_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_ALPHA_LOW:  alpha_lo_nxt = cfg_data;
        CFG_ALPHA_HIGH: alpha_hi_nxt = cfg_data;
        default: begin
          alpha_lo_nxt = alpha_lo_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alpha_lo_r <= '0;
      alpha_hi_r <= '0;
    end else begin
      alpha_lo_r <= alpha_lo_nxt;
      alpha_hi_r <= alpha_hi_nxt;
    end
  end

  // Front end: acceptance, alphabet check and digit generation.
  sdre_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_number (in_number),
    .alpha_lo  (alpha_lo_r),
    .alpha_hi  (alpha_hi_r),
    .q_full    (q_full),
    .busy      (busy),
    .fq        (fq)
  );

  // Queue of finished numbers with their digit banks.
  sdre_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .fq     (fq),
    .bq     (bq),
    .q_full (q_full),
    .qb     (qb)
  );

  // Back end: character emission.
  sdre_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .qb             (qb),
    .alpha_lo       (alpha_lo_r),
    .alpha_hi       (alpha_hi_r),
    .bq             (bq),
    .out_strobe     (out_strobe),
    .out_char       (out_char),
    .out_final_char (out_final_char)
  );

  // Checks on the queue hand-off and the emitted beats.
  `SDRE_ASSERT_NOW(a_push_room, fq.push, !q_full, "number pushed into a full queue")
  `SDRE_ASSERT_NOW(a_pop_valid, bq.pop || bq.rd_en, qb.head_valid, "queue read while empty")
  `SDRE_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "not busy after accepting a number")
  `SDRE_ASSERT_NOW(a_sign_not_last, out_strobe && out_char == CH_MINUS, !out_final_char,
    "sign beat marked as last")

endmodule
